FILE: src/pbb_pkg.sv
// Shared types and constants for the padded bounding-box crop block.
`default_nettype none

package pbb_pkg;

  // Fixed field widths
  localparam int unsigned RED_W      = 8;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned CROP_W     = 14;
  localparam int unsigned RENDER_W   = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 96;

  localparam logic [RED_W-1:0]           RED_THRESH   = 8'd2;
  localparam logic signed [RENDER_W-1:0] RENDER_LIMIT = 18'sd100000;

  // x / 5 == (x * 52429) >> 18 for all x below 2^15
  localparam logic [15:0]  DIV5_RECIP = 16'd52429;
  localparam int unsigned  DIV5_SHIFT = 18;

  localparam logic [DIM_W-1:0] DIM_RESET = 13'd4096;

  // edge_overflow_mask bit positions
  localparam int unsigned MASK_TOP    = 0;
  localparam int unsigned MASK_LEFT   = 1;
  localparam int unsigned MASK_BOTTOM = 2;
  localparam int unsigned MASK_RIGHT  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_LINE_START_ROW = 3'd2,
    REG_LINE_END_ROW   = 3'd3,
    REG_EDGE_MASK      = 3'd4,
    REG_FRAGMENT_MODE  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [ROW_W-1:0]  line_start_row;
    logic [ROW_W-1:0]  line_end_row;
    logic [MASK_W-1:0] edge_overflow_mask;
    logic              upper_fragment_mode;
  } cfg_t;

  // Result item, crop_left in the lowest bits
  typedef struct packed {
    logic [3:0]                 pad;
    logic signed [RENDER_W-1:0] render_bottom;
    logic signed [RENDER_W-1:0] render_top;
    logic signed [CROP_W-1:0]   crop_bottom;
    logic signed [CROP_W-1:0]   crop_right;
    logic signed [CROP_W-1:0]   crop_top;
    logic signed [CROP_W-1:0]   crop_left;
  } res_t;

endpackage

`default_nettype wire

FILE: src/pbb_cfg.sv
// Configuration registers and effective image limits.
`default_nettype none

module pbb_cfg #(
  parameter int unsigned MAX_DIM = 4096,
  parameter int unsigned CW      = 12
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          wr_i,
  input  wire [pbb_pkg::CFG_IDX_W-1:0] index_i,
  input  wire [pbb_pkg::CFG_DATA_W-1:0] data_i,
  output pbb_pkg::cfg_t                cfg_o,
  output logic                         rearm_o,
  output logic [CW-1:0]                col_last_o,
  output logic [CW-1:0]                row_last_o
);
  import pbb_pkg::*;

  localparam logic [CW-1:0] DIM_LAST = CW'(MAX_DIM - 1);

  cfg_t cfg_q;

  function automatic logic [CW-1:0] dim_last(input logic [DIM_W-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > int'(MAX_DIM)) begin
      r = DIM_LAST;
    end else begin
      r = CW'(int'(v) - 1);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width         <= DIM_RESET;
      cfg_q.image_height        <= DIM_RESET;
      cfg_q.line_start_row      <= '0;
      cfg_q.line_end_row        <= '0;
      cfg_q.edge_overflow_mask  <= '0;
      cfg_q.upper_fragment_mode <= 1'b0;
    end else if (wr_i) begin
      case (cfg_idx_e'(index_i))
        REG_IMAGE_WIDTH:    cfg_q.image_width         <= data_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   cfg_q.image_height        <= data_i[DIM_W-1:0];
        REG_LINE_START_ROW: cfg_q.line_start_row      <= data_i[ROW_W-1:0];
        REG_LINE_END_ROW:   cfg_q.line_end_row        <= data_i[ROW_W-1:0];
        REG_EDGE_MASK:      cfg_q.edge_overflow_mask  <= data_i[MASK_W-1:0];
        REG_FRAGMENT_MODE:  cfg_q.upper_fragment_mode <= data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rearm_o = wr_i && ((cfg_idx_e'(index_i) == REG_IMAGE_WIDTH) ||
                       (cfg_idx_e'(index_i) == REG_IMAGE_HEIGHT));
  end

  assign cfg_o      = cfg_q;
  assign col_last_o = dim_last(cfg_q.image_width);
  assign row_last_o = dim_last(cfg_q.image_height);

endmodule

`default_nettype wire

FILE: src/pbb_track.sv
// Raster position counters, running extents and the end-of-frame snapshot.
`default_nettype none

module pbb_track #(
  parameter int unsigned CW = 12
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire [pbb_pkg::RED_W-1:0] red_i,
  input  wire                      last_i,
  input  wire                      rearm_i,
  input  wire [CW-1:0]             col_last_i,
  input  wire [CW-1:0]             row_last_i,
  output logic                     snap_valid_o,
  input  wire                      snap_ready_i,
  output logic [CW-1:0]            snap_min_col_o,
  output logic [CW-1:0]            snap_max_col_o,
  output logic [CW-1:0]            snap_min_row_o,
  output logic [CW-1:0]            snap_max_row_o
);
  import pbb_pkg::*;

  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [CW-1:0] min_col_q, min_col_d, min_row_q, min_row_d;
  logic [CW-1:0] max_col_q, max_col_d, max_row_q, max_row_d;
  logic          any_q, any_d;
  logic          snap_v_q;
  logic [CW-1:0] snap_min_col_q, snap_max_col_q, snap_min_row_q, snap_max_row_q;
  logic          accept, hit;

  assign in_ready_o = !snap_v_q || snap_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign hit        = red_i > RED_THRESH;

  // any_q marks that the min registers hold a real pixel; until then the
  // minimum reads as the last column / row, as after a re-arm
  always_comb begin
    any_d     = any_q || hit;
    min_col_d = (hit && (!any_q || col_q < min_col_q)) ? col_q : min_col_q;
    min_row_d = (hit && (!any_q || row_q < min_row_q)) ? row_q : min_row_q;
    max_col_d = (hit && col_q > max_col_q) ? col_q : max_col_q;
    max_row_d = (hit && row_q > max_row_q) ? row_q : max_row_q;
    if (col_q >= col_last_i) begin
      col_d = '0;
      row_d = (row_q >= row_last_i) ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q     <= 1'b0;
      max_col_q <= '0;
      max_row_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
    end else if (rearm_i || (accept && last_i)) begin
      any_q     <= 1'b0;
      max_col_q <= '0;
      max_row_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
    end else if (accept) begin
      any_q     <= any_d;
      max_col_q <= max_col_d;
      max_row_q <= max_row_d;
      col_q     <= col_d;
      row_q     <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_col_q <= min_col_d;
      min_row_q <= min_row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_v_q <= 1'b0;
    end else if (accept && last_i) begin
      snap_v_q <= 1'b1;
    end else if (snap_ready_i) begin
      snap_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_i) begin
      snap_min_col_q <= any_d ? min_col_d : col_last_i;
      snap_min_row_q <= any_d ? min_row_d : row_last_i;
      snap_max_col_q <= max_col_d;
      snap_max_row_q <= max_row_d;
    end
  end

  assign snap_valid_o   = snap_v_q;
  assign snap_min_col_o = snap_min_col_q;
  assign snap_max_col_o = snap_max_col_q;
  assign snap_min_row_o = snap_min_row_q;
  assign snap_max_row_o = snap_max_row_q;

endmodule

`default_nettype wire

FILE: src/pbb_crop.sv
// Padding by a fifth of the extent, clamping and the result register.
`default_nettype none

module pbb_crop #(
  parameter int unsigned CW = 12
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire [CW-1:0]                   min_col_i,
  input  wire [CW-1:0]                   max_col_i,
  input  wire [CW-1:0]                   min_row_i,
  input  wire [CW-1:0]                   max_row_i,
  input  wire pbb_pkg::cfg_t             cfg_i,
  input  wire [CW-1:0]                   col_last_i,
  input  wire [CW-1:0]                   row_last_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [pbb_pkg::OUT_DATA_W-1:0] out_data_o
);
  import pbb_pkg::*;

  localparam int unsigned EW = CW + 2;
  localparam int unsigned PW = CW + 16;

  // Extent / 5, truncated toward zero
  function automatic logic signed [CW:0] pad_div5(input logic [CW-1:0] hi,
                                                  input logic [CW-1:0] lo);
    logic signed [CW:0] ext;
    logic [CW-1:0]      mag;
    logic [PW-1:0]      prod;
    logic [CW:0]        quo;
    ext  = $signed({1'b0, hi}) - $signed({1'b0, lo});
    mag  = ext[CW] ? CW'(-ext) : CW'(ext);
    prod = PW'(mag) * PW'(DIV5_RECIP);
    quo  = (CW + 1)'(prod >> DIV5_SHIFT);
    return ext[CW] ? -$signed(quo) : $signed(quo);
  endfunction

  logic                 p_v_q, o_v_q, o_ready;
  logic [CW-1:0]        p_min_col_q, p_max_col_q, p_min_row_q, p_max_row_q;
  logic signed [CW:0]   p_hpad_q, p_vpad_q;
  res_t                 res_q, res_d;

  logic signed [EW-1:0] hpad, vpad, lpad, rpad, tpad, bpad;
  logic signed [EW-1:0] min_c, max_c, min_r, max_r, col_lim, row_lim;
  logic signed [EW-1:0] left, right, top_pad, bot_pad;

  assign o_ready    = !o_v_q || out_ready_i;
  assign in_ready_o = !p_v_q || o_ready;

  // Stage 1: padding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (in_ready_o) begin
      p_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      p_min_col_q <= min_col_i;
      p_max_col_q <= max_col_i;
      p_min_row_q <= min_row_i;
      p_max_row_q <= max_row_i;
      p_hpad_q    <= pad_div5(max_col_i, min_col_i);
      p_vpad_q    <= pad_div5(max_row_i, min_row_i);
    end
  end

  // Stage 2: edges, clamps and the render limits
  always_comb begin
    hpad    = EW'(p_hpad_q);
    vpad    = EW'(p_vpad_q);
    lpad    = cfg_i.edge_overflow_mask[MASK_LEFT]   ? '0 : hpad;
    rpad    = cfg_i.edge_overflow_mask[MASK_RIGHT]  ? '0 : hpad;
    tpad    = cfg_i.edge_overflow_mask[MASK_TOP]    ? '0 : vpad;
    bpad    = cfg_i.edge_overflow_mask[MASK_BOTTOM] ? '0 : vpad;
    min_c   = $signed({2'b00, p_min_col_q});
    max_c   = $signed({2'b00, p_max_col_q});
    min_r   = $signed({2'b00, p_min_row_q});
    max_r   = $signed({2'b00, p_max_row_q});
    col_lim = $signed({2'b00, col_last_i});
    row_lim = $signed({2'b00, row_last_i});

    left    = min_c - lpad;
    right   = max_c + rpad;
    top_pad = min_r - tpad;
    bot_pad = max_r + bpad;
    if (left < 0) left = '0;
    if (right > col_lim) right = col_lim;
    if (top_pad < 0) top_pad = '0;
    if (bot_pad > row_lim) bot_pad = row_lim;

    res_d            = '0;
    res_d.crop_left  = CROP_W'(left);
    res_d.crop_right = CROP_W'(right);
    if (!cfg_i.upper_fragment_mode) begin
      // proximal: fragment above the line
      res_d.crop_top      = CROP_W'(top_pad);
      res_d.crop_bottom   = $signed({2'b00, cfg_i.line_end_row});
      res_d.render_top    = $signed({6'd0, cfg_i.line_end_row});
      res_d.render_bottom = RENDER_LIMIT;
    end else begin
      res_d.crop_top      = $signed({2'b00, cfg_i.line_end_row});
      res_d.crop_bottom   = CROP_W'(bot_pad);
      res_d.render_top    = -RENDER_LIMIT;
      res_d.render_bottom = $signed({6'd0, cfg_i.line_start_row});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_ready) begin
      o_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready && p_v_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

FILE: src/padded_bounding_box_crop.sv
// Top level of the padded bounding-box crop block.
// Takes one pixel per clock on the slave stream, every cycle, while tready is
// high; tready drops only when the result pipeline behind the end-of-frame
// snapshot is full and the master side stalls. Column and row are counted
// internally in raster order, and pixels with red above 2 widen the running
// box. The pixel marked by tlast closes the frame: its extents are captured,
// the tracker re-arms in the same cycle, and the crop result passes from the
// snapshot register through the padding register (divide-by-5 multiplier)
// and the clamp into the output register. Writing the image width or height
// restarts the current frame. Configuration is to be written between frames.
`default_nettype none

module padded_bounding_box_crop #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // tdata: pixel_red[7:0]
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire [pbb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  wire                            s_axis_tlast,
  // tdata: crop_left[13:0], crop_top[27:14], crop_right[41:28],
  //        crop_bottom[55:42], render_top[73:56], render_bottom[91:74], zero
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [pbb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [pbb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [pbb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import pbb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DIM);

  cfg_t          cfg;
  logic          rearm;
  logic [CW-1:0] col_last, row_last;
  logic          snap_valid, snap_ready;
  logic [CW-1:0] snap_min_col, snap_max_col, snap_min_row, snap_max_row;

  assign cfg_ready_o = 1'b1;

  pbb_cfg #(
    .MAX_DIM (MAX_DIM),
    .CW      (CW)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (cfg_valid_i && cfg_ready_o),
    .index_i    (cfg_index_i),
    .data_i     (cfg_data_i),
    .cfg_o      (cfg),
    .rearm_o    (rearm),
    .col_last_o (col_last),
    .row_last_o (row_last)
  );

  pbb_track #(
    .CW (CW)
  ) u_track (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .red_i          (s_axis_tdata[RED_W-1:0]),
    .last_i         (s_axis_tlast),
    .rearm_i        (rearm),
    .col_last_i     (col_last),
    .row_last_i     (row_last),
    .snap_valid_o   (snap_valid),
    .snap_ready_i   (snap_ready),
    .snap_min_col_o (snap_min_col),
    .snap_max_col_o (snap_max_col),
    .snap_min_row_o (snap_min_row),
    .snap_max_row_o (snap_max_row)
  );

  pbb_crop #(
    .CW (CW)
  ) u_crop (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (snap_valid),
    .in_ready_o  (snap_ready),
    .min_col_i   (snap_min_col),
    .max_col_i   (snap_max_col),
    .min_row_i   (snap_min_row),
    .max_row_i   (snap_max_row),
    .cfg_i       (cfg),
    .col_last_i  (col_last),
    .row_last_i  (row_last),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking stream testbench for the padded bounding-box crop block.
`default_nettype none

module tb;
  import pbb_pkg::*;

  localparam int MAX_DIM         = 4096;
  localparam int UNBOUNDED_ROW   = 100000;
  localparam int SETTLE_CYCLES   = 6;
  localparam int WATCHDOG_CYCLES = 1000;
  localparam int PIXEL_TARGET    = 950;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic {STEP_PIXEL, STEP_REG} step_kind_e;

  typedef struct packed {
    step_kind_e            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [RED_W-1:0]      red;
    logic                  last;
    logic                  typed;
    res_t                  want;
  } step_t;

  // single lit pixel at the origin of a 4096 x 4096 frame
  localparam res_t ORIGIN_CROP = '{pad: '0, render_bottom: 18'sd100000, render_top: '0,
                                   crop_bottom: '0, crop_right: '0, crop_top: '0,
                                   crop_left: '0};
  // empty 4096 x 4096 frame: negative padding pushes the edges outwards
  localparam res_t EMPTY_CROP = '{pad: '0, render_bottom: 18'sd100000, render_top: '0,
                                  crop_bottom: '0, crop_right: -14'sd819,
                                  crop_top: 14'sd4914, crop_left: 14'sd4914};
  localparam res_t NO_CROP = '0;

  localparam int SCRIPT_LEN = 38;
  localparam step_t SCRIPT [SCRIPT_LEN] = '{
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd255, 1'b1, 1'b1, ORIGIN_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd0,   1'b1, 1'b1, EMPTY_CROP},
    '{STEP_REG, REG_IMAGE_WIDTH,    13'd4,    8'd0, 1'b0, 1'b0, NO_CROP},
    '{STEP_REG, REG_IMAGE_HEIGHT,   13'd3,    8'd0, 1'b0, 1'b0, NO_CROP},
    '{STEP_REG, REG_LINE_START_ROW, 13'd5,    8'd0, 1'b0, 1'b0, NO_CROP},
    '{STEP_REG, REG_LINE_END_ROW,   13'd4095, 8'd0, 1'b0, 1'b0, NO_CROP},
    '{STEP_REG, REG_EDGE_MASK,      13'd0,    8'd0, 1'b0, 1'b0, NO_CROP},
    '{STEP_REG, REG_FRAGMENT_MODE,  13'd1,    8'd0, 1'b0, 1'b0, NO_CROP},
    // 4 x 3 frame, threshold straddled by 2 and 3
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd0,   1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd2,   1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd3,   1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd0,   1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd2,   1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd0,   1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd0,   1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd255, 1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd0,   1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd1,   1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd0,   1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd2,   1'b1, 1'b0, NO_CROP},
    '{STEP_REG, REG_EDGE_MASK,      13'd15,   8'd0, 1'b0, 1'b0, NO_CROP},
    '{STEP_REG, REG_FRAGMENT_MODE,  13'd0,    8'd0, 1'b0, 1'b0, NO_CROP},
    '{STEP_REG, REG_IMAGE_WIDTH,    13'd2,    8'd0, 1'b0, 1'b0, NO_CROP},
    '{STEP_REG, REG_IMAGE_HEIGHT,   13'd2,    8'd0, 1'b0, 1'b0, NO_CROP},
    // frame overruns 2 x 2 and wraps back to row 0
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd9,   1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd0,   1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd0,   1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd0,   1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd0,   1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd7,   1'b1, 1'b0, NO_CROP},
    '{STEP_REG, REG_UNUSED,         13'd8191, 8'd0, 1'b0, 1'b0, NO_CROP},
    '{STEP_REG, REG_IMAGE_WIDTH,    13'd0,    8'd0, 1'b0, 1'b0, NO_CROP},
    '{STEP_REG, REG_IMAGE_HEIGHT,   13'd8191, 8'd0, 1'b0, 1'b0, NO_CROP},
    '{STEP_REG, REG_LINE_START_ROW, 13'd4095, 8'd0, 1'b0, 1'b0, NO_CROP},
    '{STEP_REG, REG_EDGE_MASK,      13'd5,    8'd0, 1'b0, 1'b0, NO_CROP},
    '{STEP_REG, REG_FRAGMENT_MODE,  13'd1,    8'd0, 1'b0, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd128, 1'b1, 1'b0, NO_CROP},
    '{STEP_PIXEL, 3'd0, 13'd0, 8'd1,   1'b1, 1'b0, NO_CROP}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  always #4 clk_i = ~clk_i;

  padded_bounding_box_crop #(.MAX_DIM(MAX_DIM)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // shadow copy of the block's registers and box tracker
  logic [DIM_W-1:0]  img_w, img_h;
  logic [ROW_W-1:0]  line_start, line_end;
  logic [MASK_W-1:0] pad_mask;
  logic              distal;
  int box_x0, box_y0, box_x1, box_y1, col_pos, row_pos;

  res_t pending_crops [$];
  bit   quiet;
  bit   stream_busy;
  bit   run_over;
  int   errors;
  int   pixels_sent;
  int   reg_writes;
  int   crops_checked;
  int   sink_hold;
  int   stall_run;

  function automatic int eff_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // mostly short gaps, now and then a long one; none in quiet stretches
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic rearm_box();
    box_x0  = eff_dim(img_w) - 1;
    box_y0  = eff_dim(img_h) - 1;
    box_x1  = 0;
    box_y1  = 0;
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic track_pixel(input logic [RED_W-1:0] red, input logic last,
                             output bit emits, output res_t crop);
    int w, h, x, y, hpad, vpad, left, right, top, bottom, rtop, rbot;
    w     = eff_dim(img_w);
    h     = eff_dim(img_h);
    x     = col_pos;
    y     = row_pos;
    emits = 1'b0;
    crop  = '0;
    if (red > RED_THRESH) begin
      if (x < box_x0) box_x0 = x;
      if (y < box_y0) box_y0 = y;
      if (x > box_x1) box_x1 = x;
      if (y > box_y1) box_y1 = y;
    end
    if (x >= w - 1) begin
      col_pos = 0;
      row_pos = (y >= h - 1) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
    if (last) begin
      // truncates toward zero, so an empty frame gives negative padding
      hpad  = (box_x1 - box_x0) / 5;
      vpad  = (box_y1 - box_y0) / 5;
      left  = box_x0 - (pad_mask[MASK_LEFT] ? 0 : hpad);
      right = box_x1 + (pad_mask[MASK_RIGHT] ? 0 : hpad);
      if (left < 0) left = 0;
      if (right > w - 1) right = w - 1;
      if (!distal) begin
        top    = box_y0 - (pad_mask[MASK_TOP] ? 0 : vpad);
        if (top < 0) top = 0;
        bottom = int'(line_end);
        rtop   = int'(line_end);
        rbot   = UNBOUNDED_ROW;
      end else begin
        top    = int'(line_end);
        bottom = box_y1 + (pad_mask[MASK_BOTTOM] ? 0 : vpad);
        if (bottom > h - 1) bottom = h - 1;
        rtop   = -UNBOUNDED_ROW;
        rbot   = int'(line_start);
      end
      crop.crop_left     = left[CROP_W-1:0];
      crop.crop_top      = top[CROP_W-1:0];
      crop.crop_right    = right[CROP_W-1:0];
      crop.crop_bottom   = bottom[CROP_W-1:0];
      crop.render_top    = rtop[RENDER_W-1:0];
      crop.render_bottom = rbot[RENDER_W-1:0];
      emits = 1'b1;
      rearm_box();
    end
  endtask

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // hold the stream until every crop is back and the pipeline has drained
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b0;
    while (pending_crops.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    stream_busy = 1'b0;
  endtask

  task automatic send_pixel(input logic [RED_W-1:0] red, input logic last,
                            input logic typed, input res_t typed_crop);
    int   gap;
    bit   emits;
    res_t crop;
    gap = idle_gap();
    cfg_valid_i <= 1'b0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= red;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_pixel(red, last, emits, crop);
    if (emits) pending_crops.push_back(typed ? typed_crop : crop);
    stream_busy = 1'b1;
    pixels_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    if (stream_busy) settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_IMAGE_WIDTH:    begin img_w = data; rearm_box(); end
      REG_IMAGE_HEIGHT:   begin img_h = data; rearm_box(); end
      REG_LINE_START_ROW: line_start = data[ROW_W-1:0];
      REG_LINE_END_ROW:   line_end = data[ROW_W-1:0];
      REG_EDGE_MASK:      pad_mask = data[MASK_W-1:0];
      REG_FRAGMENT_MODE:  distal = data[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CFG_DATA_W'($urandom_range(1, 12));
    if (r < 80) return CFG_DATA_W'($urandom_range(13, 64));
    if (r < 88) return '0;
    if (r < 94) return DIM_RESET;
    return CFG_DATA_W'($urandom_range(0, 8191));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_row();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return CFG_DATA_W'($urandom_range(0, 15));
    if (r < 60) return 13'd4095;
    return CFG_DATA_W'($urandom_range(0, 8191));
  endfunction

  // result sink with random back-pressure
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      sink_hold     <= idle_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata);
      if (pending_crops.size() == 0) begin
        flag_error("crop item arrived with none outstanding");
      end else begin
        want = pending_crops.pop_front();
        compare_field("crop_left",     int'(got.crop_left),     int'(want.crop_left));
        compare_field("crop_top",      int'(got.crop_top),      int'(want.crop_top));
        compare_field("crop_right",    int'(got.crop_right),    int'(want.crop_right));
        compare_field("crop_bottom",   int'(got.crop_bottom),   int'(want.crop_bottom));
        compare_field("render_top",    int'(got.render_top),    int'(want.render_top));
        compare_field("render_bottom", int'(got.render_bottom), int'(want.render_bottom));
        compare_field("tdata padding", int'(got.pad),           0);
        crops_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || run_over) begin
      stall_run <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      stall_run <= 0;
    end else if (stall_run >= WATCHDOG_CYCLES) begin
      $display("Watchdog: no handshake for %0d cycles, %0d crops outstanding",
               WATCHDOG_CYCLES, pending_crops.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_run <= stall_run + 1;
    end
  end

  initial begin
    int style, len, area, dens;
    logic [RED_W-1:0] red;
    logic             last;
    img_w      = DIM_RESET;
    img_h      = DIM_RESET;
    line_start = '0;
    line_end   = '0;
    pad_mask   = '0;
    distal     = 1'b0;
    rearm_box();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == STEP_REG) write_reg(SCRIPT[i].idx, SCRIPT[i].data);
      else send_pixel(SCRIPT[i].red, SCRIPT[i].last, SCRIPT[i].typed, SCRIPT[i].want);
    end

    while (pixels_sent < PIXEL_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1)) write_reg(REG_IMAGE_WIDTH, pick_size());
        if ($urandom_range(0, 1)) write_reg(REG_IMAGE_HEIGHT, pick_size());
        if ($urandom_range(0, 1)) write_reg(REG_LINE_START_ROW, pick_row());
        if ($urandom_range(0, 1)) write_reg(REG_LINE_END_ROW, pick_row());
        if ($urandom_range(0, 1))
          write_reg(REG_EDGE_MASK, CFG_DATA_W'($urandom_range(0, 8191)));
        if ($urandom_range(0, 1))
          write_reg(REG_FRAGMENT_MODE, CFG_DATA_W'($urandom_range(0, 8191)));
        if ($urandom_range(0, 9) == 0)
          write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 8191)));
      end
      if ($urandom_range(0, 9) == 0) settle();
      quiet = ($urandom_range(0, 4) == 0);
      area  = eff_dim(img_w) * eff_dim(img_h);
      style = $urandom_range(0, 9);
      dens  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(5, 60);
      // 0..7 frames, whole if area <= 80; 8 random length; 9 tlast noise
      if (style < 8) len = (area <= 80) ? area : $urandom_range(1, 48);
      else len = $urandom_range(1, (area <= 50) ? 2 * area : 100);
      for (int n = 0; n < len; n++) begin
        if ($urandom_range(0, 19) == 0) red = RED_W'($urandom_range(0, 255));
        else if ($urandom_range(0, 99) < dens) red = RED_W'($urandom_range(3, 255));
        else red = RED_W'($urandom_range(0, 2));
        last = (style == 9) ? ($urandom_range(0, 9) == 0) : (n == len - 1);
        send_pixel(red, last, 1'b0, NO_CROP);
      end
    end

    settle();
    run_over = 1'b1;
    $display("Run covered %0d pixels and %0d register writes; %0d crop items checked.",
             pixels_sent, reg_writes, crops_checked);
    $display("Frames mixed well-formed, overlong, truncated and empty, with random stalls.");
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
